// ----- hw/rtl/lir_pkg.sv -----
`default_nettype none

package lir_pkg;

	localparam int SAMPLE_W     = 32;
	localparam int RATE_W       = 25;
	localparam int CC_W         = 4;
	localparam int CH_W         = 3;
	localparam int COUNT_W      = 32;
	localparam int MAX_CHANNELS = 8;
	localparam int FIFO_DEPTH   = 4;
	localparam int OUT_DATA_W   = 40;

	localparam int DEF_MAX_UPSAMPLE  = 8;
	localparam int DEF_FRACTION_BITS = 16;

	// divider and multiplier sizing
	localparam int DIV_W      = 64;
	localparam int DIV_STEP_W = 7;
	localparam int TGT_W      = 58;
	localparam int MUL_A_W    = 35;
	localparam int MUL_B_W    = 26;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;

	localparam logic [RATE_W-1:0] RESET_FROM_RATE     = 25'd4800000;
	localparam logic [RATE_W-1:0] RESET_TO_RATE       = 25'd4800000;
	localparam logic [CC_W-1:0]   RESET_CHANNEL_COUNT = 4'd2;
	localparam logic              RESET_WIDE_SAMPLES  = 1'b0;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FROM_RATE     = 2'd0,
		REG_TO_RATE       = 2'd1,
		REG_CHANNEL_COUNT = 2'd2,
		REG_WIDE_SAMPLES  = 2'd3
	} cfg_reg_t;

	// one queued sample, classified by the front end
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [CH_W-1:0]     pos;
		logic                frame_end;
		logic [CC_W-1:0]     chans;
	} item_t;

	typedef struct packed {
		logic [RATE_W-1:0] from_rate;
		logic [RATE_W-1:0] to_rate;
		logic              clear;
	} rate_cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/linear_interpolation_resampler_unit.sv -----
// A sample that does not close a frame is stored into the frame as it leaves the queue.
// A frame-closing sample: a divide for the target count, then per output frame a divide for the
//   fraction (skipped when it clamps) and a multiply and emit per channel, then count reduction
//   (up to two divides); the serial divider runs all of these divides.
// The queue keeps taking samples while the back end works on a frame, until it is full.
// Reset: arst_n asynchronous, active low; counts, frames and queue clear, registers to defaults.
`default_nettype none

module linear_interpolation_resampler_unit import lir_pkg::*; #(
	parameter int MAX_UPSAMPLE  = DEF_MAX_UPSAMPLE,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [SAMPLE_W-1:0]  s_tdata,   // [31:0] sample
	// output stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [OUT_DATA_W-1:0]     m_tdata,   // [31:0] out_sample, [34:32] out_channel, pad
	output logic                      m_tlast,   // last_of_run
	output logic [0:0]                m_tuser,   // [0] clipped
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [RATE_W-1:0]    cfg_data
);

	logic [RATE_W-1:0] from_rate_q;
	logic [RATE_W-1:0] to_rate_q;
	logic [CC_W-1:0]   channel_count_q;
	logic              wide_samples_q;

	logic      cfg_wr;
	rate_cfg_t rcfg;

	item_t push_item;
	item_t pop_item;
	logic  push;
	logic  pop;
	logic  full;
	logic  empty;

	// writes are always accepted; software must write only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			from_rate_q     <= RESET_FROM_RATE;
			to_rate_q       <= RESET_TO_RATE;
			channel_count_q <= RESET_CHANNEL_COUNT;
			wide_samples_q  <= RESET_WIDE_SAMPLES;
		end else if (cfg_wr) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FROM_RATE:     from_rate_q     <= cfg_data;
				REG_TO_RATE:       to_rate_q       <= cfg_data;
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[CC_W-1:0];
				REG_WIDE_SAMPLES:  wide_samples_q  <= cfg_data[0];
			endcase
		end
	end

	// the rate registers feed the back end directly; a rate transfer clears
	// its counts in the same edge
	always_comb begin
		rcfg.from_rate = from_rate_q;
		rcfg.to_rate   = to_rate_q;
		rcfg.clear     = cfg_wr && ((cfg_reg_t'(cfg_index) == REG_FROM_RATE)
			|| (cfg_reg_t'(cfg_index) == REG_TO_RATE));
	end

	// front: sign extension and frame position tracking
	lir_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.channel_count (channel_count_q),
		.wide_samples  (wide_samples_q),
		.full          (full),
		.push          (push),
		.item          (push_item)
	);

	// short queue so sample intake keeps going while a frame is computed
	lir_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (push_item),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.rd_item (pop_item)
	);

	// back: frame store, phase math, interpolation and output register
	lir_back #(
		.MAX_UPSAMPLE  (MAX_UPSAMPLE),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rcfg     (rcfg),
		.item     (pop_item),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/lir_front.sv -----
`default_nettype none

module lir_front import lir_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [SAMPLE_W-1:0] s_tdata,
	input  wire logic [CC_W-1:0]     channel_count,
	input  wire logic                wide_samples,
	input  wire logic                full,
	output logic                     push,
	output item_t                    item
);

	logic [CH_W-1:0] pos_q;
	logic [CC_W-1:0] cc_eff;
	logic [CC_W-1:0] nxt;
	logic            frame_end;

	always_comb begin
		if (channel_count == '0) begin
			cc_eff = CC_W'(1);
		end else if (channel_count > CC_W'(MAX_CHANNELS)) begin
			cc_eff = CC_W'(MAX_CHANNELS);
		end else begin
			cc_eff = channel_count;
		end
	end

	assign nxt       = {1'b0, pos_q} + CC_W'(1);
	assign frame_end = !(nxt < cc_eff);

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	always_comb begin
		item.sample    = wide_samples ? s_tdata : {{16{s_tdata[15]}}, s_tdata[15:0]};
		item.pos       = pos_q;
		item.frame_end = frame_end;
		item.chans     = cc_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= frame_end ? '0 : nxt[CH_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lir_fifo.sv -----
`default_nettype none

module lir_fifo import lir_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  item_t     wr_item,
	output logic      full,
	input  wire logic pop,
	output logic      empty,
	output item_t     rd_item
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	item_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lir_div.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle; dividend is left aligned
module lir_div import lir_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIV_W-1:0]      dividend,
	input  wire logic [DIV_STEP_W-1:0] steps,
	input  wire logic [RATE_W-1:0]     divisor,
	output logic                       done,
	output logic [DIV_W-1:0]           quotient
);

	logic [DIV_W-1:0]      dvd_q;
	logic [DIV_W-1:0]      quo_q;
	logic [RATE_W-1:0]     rem_q;
	logic [RATE_W-1:0]     dsr_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [RATE_W:0] trial;
	logic [RATE_W:0] diff;
	logic            ge;

	assign trial    = {rem_q, dvd_q[DIV_W-1]};
	assign diff     = trial - {1'b0, dsr_q};
	assign ge       = (trial >= {1'b0, dsr_q});
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			quo_q <= '0;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_STEP_W'(1);
				if (cnt_q == DIV_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lir_back.sv -----
`default_nettype none

module lir_back import lir_pkg::*; #(
	parameter int MAX_UPSAMPLE  = DEF_MAX_UPSAMPLE,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  rate_cfg_t                  rcfg,
	input  item_t                      item,
	input  wire logic                  empty,
	output logic                       pop,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tlast,
	output logic [0:0]                 m_tuser
);

	localparam int UP_W       = $clog2(MAX_UPSAMPLE + 1);
	localparam int FRAC_STEPS = RATE_W + FRACTION_BITS;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MNT, ST_TGT_GO, ST_TGT_WAIT, ST_TGT_CHK, ST_MDF, ST_NUM,
		ST_FWAIT, ST_MCH, ST_EMIT, ST_FIN, ST_RCHK, ST_KSW, ST_KOW, ST_MKF,
		ST_MKT, ST_SUBT
	} state_t;

	state_t state_q;

	logic [SAMPLE_W-1:0]      cur_q  [MAX_CHANNELS];
	logic [SAMPLE_W-1:0]      prev_q [MAX_CHANNELS];
	logic [CC_W-1:0]          cc_q;
	logic [COUNT_W-1:0]       n_q;
	logic [COUNT_W-1:0]       sc_q;
	logic [COUNT_W-1:0]       oc_q;
	logic                     have_prev_q;
	logic signed [PROD_W-1:0] nt1_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [TGT_W-1:0]         tgt_q;
	logic [UP_W-1:0]          emit_q;
	logic [UP_W-1:0]          i_q;
	logic                     clip_q;
	logic [CH_W-1:0]          ch_q;
	logic [FRACTION_BITS-1:0] frac_q;
	logic [COUNT_W-1:0]       ks_q;
	logic [COUNT_W-1:0]       k_q;

	logic                     ov_q;
	logic [SAMPLE_W-1:0]      osample_q;
	logic [CH_W-1:0]          och_q;
	logic                     olast_q;
	logic                     oclip_q;

	logic [RATE_W-1:0]         f_eff;
	logic [RATE_W-1:0]         t_eff;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic [COUNT_W:0]          d_pos;
	logic signed [SAMPLE_W:0]  diff;
	logic signed [PROD_W-1:0]  tsum;
	logic signed [PROD_W-1:0]  num;
	logic                      num_ge_t;
	logic [TGT_W-1:0]          total;
	logic signed [PROD_W-1:0]  adj;
	logic signed [PROD_W-1:0]  shifted;
	logic [SAMPLE_W-1:0]       result;
	logic                      last_i;
	logic                      last_ch;
	logic                      out_free;
	logic [COUNT_W-1:0]        sc_next;

	logic                  div_start;
	logic [DIV_W-1:0]      div_dvd;
	logic [DIV_STEP_W-1:0] div_steps;
	logic [RATE_W-1:0]     div_dsr;
	logic                  div_done;
	logic [DIV_W-1:0]      div_quo;

	lir_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.steps    (div_steps),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign f_eff = (rcfg.from_rate == '0) ? RATE_W'(1) : rcfg.from_rate;
	assign t_eff = (rcfg.to_rate == '0) ? RATE_W'(1) : rcfg.to_rate;

	assign d_pos = {1'b0, oc_q} + (COUNT_W + 1)'(i_q);
	assign diff  = $signed({cur_q[ch_q][SAMPLE_W-1], cur_q[ch_q]})
		- $signed({prev_q[ch_q][SAMPLE_W-1], prev_q[ch_q]});

	// shared multiplier, operands picked by state
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MNT: begin
				mul_a = $signed(MUL_A_W'({3'b000, n_q}) - MUL_A_W'(1));
				mul_b = $signed({1'b0, t_eff});
			end
			ST_MDF: begin
				mul_a = $signed(MUL_A_W'(d_pos));
				mul_b = $signed({1'b0, f_eff});
			end
			ST_MCH: begin
				mul_a = MUL_A_W'(diff);
				mul_b = $signed(MUL_B_W'(frac_q));
			end
			ST_MKF: begin
				mul_a = $signed(MUL_A_W'(k_q));
				mul_b = $signed({1'b0, f_eff});
			end
			ST_MKT: begin
				mul_a = $signed(MUL_A_W'(k_q));
				mul_b = $signed({1'b0, t_eff});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// (n-1)*t + t + f - 1 = n*t + f - 1
	assign tsum     = prod_q + $signed(PROD_W'(t_eff)) + $signed(PROD_W'(f_eff))
		- $signed(PROD_W'(1));
	assign num      = prod_q - nt1_q;
	assign num_ge_t = (num >= $signed(PROD_W'(t_eff)));
	assign total    = tgt_q - TGT_W'(oc_q);

	// product scaled back by the fraction, truncating toward zero
	assign adj     = prod_q + (prod_q[PROD_W-1]
		? $signed({{(PROD_W - FRACTION_BITS){1'b0}}, {FRACTION_BITS{1'b1}}})
		: $signed(PROD_W'(0)));
	assign shifted = adj >>> FRACTION_BITS;
	assign result  = prev_q[ch_q] + shifted[SAMPLE_W-1:0];

	assign last_i   = (i_q == emit_q - UP_W'(1));
	assign last_ch  = (({1'b0, ch_q} + CC_W'(1)) == cc_q);
	assign out_free = !ov_q || m_tready;
	assign sc_next  = n_q + COUNT_W'(1);

	assign pop = (state_q == ST_IDLE) && !empty;

	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_steps = '0;
		div_dsr   = f_eff;
		unique case (state_q)
			ST_TGT_GO: begin
				div_start = 1'b1;
				div_dvd   = {tsum[TGT_W-1:0], {(DIV_W - TGT_W){1'b0}}};
				div_steps = DIV_STEP_W'(TGT_W);
				div_dsr   = f_eff;
			end
			ST_NUM: begin
				div_start = !num[PROD_W-1] && !num_ge_t;
				div_dvd   = {num[RATE_W-1:0], {(DIV_W - RATE_W){1'b0}}};
				div_steps = DIV_STEP_W'(FRAC_STEPS);
				div_dsr   = t_eff;
			end
			ST_RCHK: begin
				div_start = (sc_q != '0) && (oc_q != '0);
				div_dvd   = {sc_q - COUNT_W'(1), {(DIV_W - COUNT_W){1'b0}}};
				div_steps = DIV_STEP_W'(COUNT_W);
				div_dsr   = f_eff;
			end
			ST_KSW: begin
				div_start = div_done;
				div_dvd   = {oc_q - COUNT_W'(1), {(DIV_W - COUNT_W){1'b0}}};
				div_steps = DIV_STEP_W'(COUNT_W);
				div_dsr   = t_eff;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {{(OUT_DATA_W - SAMPLE_W - CH_W){1'b0}}, och_q, osample_q};
	assign m_tlast  = olast_q;
	assign m_tuser  = oclip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int c = 0; c < MAX_CHANNELS; c++) begin
				cur_q[c]  <= '0;
				prev_q[c] <= '0;
			end
			cc_q        <= '0;
			n_q         <= '0;
			sc_q        <= '0;
			oc_q        <= '0;
			have_prev_q <= 1'b0;
			nt1_q       <= '0;
			prod_q      <= '0;
			tgt_q       <= '0;
			emit_q      <= '0;
			i_q         <= '0;
			clip_q      <= 1'b0;
			ch_q        <= '0;
			frac_q      <= '0;
			ks_q        <= '0;
			k_q         <= '0;
			ov_q        <= 1'b0;
			osample_q   <= '0;
			och_q       <= '0;
			olast_q     <= 1'b0;
			oclip_q     <= 1'b0;
		end else begin
			if (ov_q && m_tready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						cur_q[item.pos] <= item.sample;
						if (item.frame_end) begin
							cc_q    <= item.chans;
							n_q     <= sc_q;
							state_q <= have_prev_q ? ST_MNT : ST_FIN;
						end
					end
				end
				ST_MNT: begin
					prod_q  <= mul_p;
					state_q <= ST_TGT_GO;
				end
				ST_TGT_GO: begin
					nt1_q   <= prod_q;
					state_q <= ST_TGT_WAIT;
				end
				ST_TGT_WAIT: begin
					if (div_done) begin
						tgt_q   <= div_quo[TGT_W-1:0];
						state_q <= ST_TGT_CHK;
					end
				end
				ST_TGT_CHK: begin
					i_q <= '0;
					if (tgt_q > TGT_W'(oc_q)) begin
						if (total > TGT_W'(MAX_UPSAMPLE)) begin
							emit_q <= UP_W'(MAX_UPSAMPLE);
							clip_q <= 1'b1;
						end else begin
							emit_q <= total[UP_W-1:0];
							clip_q <= 1'b0;
						end
						state_q <= ST_MDF;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_MDF: begin
					prod_q  <= mul_p;
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					ch_q <= '0;
					priority if (num[PROD_W-1]) begin
						frac_q  <= '0;
						state_q <= ST_MCH;
					end else if (num_ge_t) begin
						frac_q  <= '1;
						state_q <= ST_MCH;
					end else begin
						state_q <= ST_FWAIT;
					end
				end
				ST_FWAIT: begin
					if (div_done) begin
						frac_q  <= div_quo[FRACTION_BITS-1:0];
						state_q <= ST_MCH;
					end
				end
				ST_MCH: begin
					prod_q  <= mul_p;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						ov_q      <= 1'b1;
						osample_q <= result;
						och_q     <= ch_q;
						olast_q   <= last_i && last_ch;
						oclip_q   <= clip_q;
						if (last_ch) begin
							ch_q <= '0;
							if (last_i) begin
								oc_q    <= (|tgt_q[TGT_W-1:COUNT_W]) ? '1
									: tgt_q[COUNT_W-1:0];
								state_q <= ST_FIN;
							end else begin
								i_q     <= i_q + UP_W'(1);
								state_q <= ST_MDF;
							end
						end else begin
							ch_q    <= ch_q + CH_W'(1);
							state_q <= ST_MCH;
						end
					end
				end
				ST_FIN: begin
					for (int c = 0; c < MAX_CHANNELS; c++) begin
						prev_q[c] <= cur_q[c];
					end
					have_prev_q <= 1'b1;
					sc_q        <= sc_next;
					state_q     <= ST_RCHK;
				end
				ST_RCHK: begin
					state_q <= div_start ? ST_KSW : ST_IDLE;
				end
				ST_KSW: begin
					if (div_done) begin
						ks_q    <= div_quo[COUNT_W-1:0];
						state_q <= ST_KOW;
					end
				end
				ST_KOW: begin
					if (div_done) begin
						k_q     <= (ks_q < div_quo[COUNT_W-1:0]) ? ks_q
							: div_quo[COUNT_W-1:0];
						state_q <= ST_MKF;
					end
				end
				ST_MKF: begin
					prod_q  <= mul_p;
					state_q <= ST_MKT;
				end
				ST_MKT: begin
					sc_q    <= sc_q - prod_q[COUNT_W-1:0];
					prod_q  <= mul_p;
					state_q <= ST_SUBT;
				end
				ST_SUBT: begin
					oc_q    <= oc_q - prod_q[COUNT_W-1:0];
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// a rate write restarts phase tracking
			if (rcfg.clear) begin
				sc_q        <= '0;
				oc_q        <= '0;
				have_prev_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lir_checker.sv -----
`default_nettype none

module lir_checker import lir_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic                  m_tlast,
	input wire logic [0:0]            m_tuser
);

	logic            mid_q;
	logic [CH_W-1:0] ch_q;
	logic            user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q  <= 1'b0;
			ch_q   <= '0;
			user_q <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			mid_q  <= !m_tlast;
			ch_q   <= m_tdata[SAMPLE_W +: CH_W];
			user_q <= m_tuser[0];
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output changed while stalled");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:SAMPLE_W+CH_W] == '0)
		else $error("tdata padding not zero");

	a_clip_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && mid_q |-> m_tuser[0] == user_q)
		else $error("clip flag changed within a run");

	a_chan_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && mid_q |-> (m_tdata[SAMPLE_W +: CH_W] == ch_q + CH_W'(1))
			|| (m_tdata[SAMPLE_W +: CH_W] == '0))
		else $error("channel order broken within a run");

endmodule

bind linear_interpolation_resampler_unit lir_checker u_lir_checker (.*);

`default_nettype wire

// ----- verif/resample_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module resample_checker import lir_pkg::*; #(
	parameter int MAX_UPSAMPLE  = DEF_MAX_UPSAMPLE,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [SAMPLE_W-1:0]  s_tdata,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic                 m_tlast,
	input  wire logic [0:0]           m_tuser,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [RATE_W-1:0]    cfg_data,
	output int                        errors,
	output int                        pending
);

	typedef struct packed {
		logic [31:0] value;
		logic [2:0]  chan;
		logic        last;
		logic        clip;
	} out_sample_t;

	out_sample_t expected_samples[$];

	logic [RATE_W-1:0] from_rate, to_rate;
	logic [CC_W-1:0]   chan_cfg;
	logic              wide;
	logic [31:0]       prev_frame[MAX_CHANNELS];
	logic [31:0]       cur_frame[MAX_CHANNELS];
	logic [2:0]        chan_pos;
	logic              have_prev;
	logic [31:0]       src_cnt, dst_cnt;
	int                err_cnt;

	assign errors  = err_cnt;
	assign pending = expected_samples.size();

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		$display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
		err_cnt++;
	endtask

	task automatic reduce_counts(longint unsigned f, longint unsigned t);
		longint unsigned ks, ko, k;
		if (src_cnt == 0 || dst_cnt == 0)
			return;
		ks = (longint'(src_cnt) - 1) / f;
		ko = (longint'(dst_cnt) - 1) / t;
		k = (ks < ko) ? ks : ko;
		src_cnt = 32'(longint'(src_cnt) - k * f);
		dst_cnt = 32'(longint'(dst_cnt) - k * t);
	endtask

	// Collect one sample; on frame close, queue the owed output frames, at most MAX_UPSAMPLE of them.
	task automatic interpolate_sample(logic [31:0] din);
		int unsigned     cc;
		logic [2:0]      pos;
		logic [31:0]     raw;
		longint unsigned f, t, n, target, total, emit;
		longint          num, frac, p, c, r;
		logic            clip;
		int              first;
		out_sample_t     o;
		cc = (chan_cfg == 0) ? 1 : (chan_cfg > MAX_CHANNELS) ? MAX_CHANNELS : chan_cfg;
		pos = chan_pos;
		raw = wide ? din : {{16{din[15]}}, din[15:0]};
		f = (from_rate == 0) ? 1 : from_rate;
		t = (to_rate == 0) ? 1 : to_rate;
		first = expected_samples.size();
		cur_frame[pos] = raw;
		if (pos + 1 < cc) begin
			chan_pos = 3'(pos + 1);
			return;
		end
		chan_pos = 0;
		n = src_cnt;
		if (have_prev) begin
			target = (n * t + f - 1) / f;
			if (target > dst_cnt) begin
				total = target - dst_cnt;
				emit = (total > MAX_UPSAMPLE) ? MAX_UPSAMPLE : total;
				clip = total > MAX_UPSAMPLE;
				for (longint unsigned i = 0; i < emit; i++) begin
					num = longint'(dst_cnt + i) * longint'(f) - (longint'(n) - 1) * longint'(t);
					if (num < 0)
						num = 0;
					if (num >= longint'(t))
						frac = (longint'(1) << FRACTION_BITS) - 1;
					else
						frac = (num << FRACTION_BITS) / longint'(t);
					for (int ch = 0; ch < cc; ch++) begin
						p = longint'($signed(prev_frame[ch]));
						c = longint'($signed(cur_frame[ch]));
						// signed divide truncates toward zero
						r = p + (frac * (c - p)) / (longint'(1) << FRACTION_BITS);
						o.value = r[31:0];
						o.chan  = ch[2:0];
						o.last  = 1'b0;
						o.clip  = clip;
						expected_samples.push_back(o);
					end
				end
				dst_cnt = (target > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : target[31:0];
			end
		end
		prev_frame = cur_frame;
		have_prev = 1'b1;
		src_cnt = 32'(n + 1);
		reduce_counts(f, t);
		if (expected_samples.size() > first)
			expected_samples[expected_samples.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_sample_t want;
		if (!arst_n) begin
			expected_samples.delete();
			from_rate = RESET_FROM_RATE;
			to_rate   = RESET_TO_RATE;
			chan_cfg  = RESET_CHANNEL_COUNT;
			wide      = RESET_WIDE_SAMPLES;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				prev_frame[i] = '0;
				cur_frame[i]  = '0;
			end
			chan_pos  = '0;
			have_prev = 1'b0;
			src_cnt   = '0;
			dst_cnt   = '0;
			err_cnt   = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: output transfer with nothing expected: %h", $realtime, m_tdata);
					err_cnt++;
				end else begin
					want = expected_samples.pop_front();
					if (m_tdata[31:0] !== want.value)
						report_mismatch("out_sample", want.value, m_tdata[31:0]);
					if (m_tdata[34:32] !== want.chan)
						report_mismatch("out_channel", want.chan, m_tdata[34:32]);
					if (m_tlast !== want.last)
						report_mismatch("last_of_run", want.last, m_tlast);
					if (m_tuser[0] !== want.clip)
						report_mismatch("clipped", want.clip, m_tuser[0]);
				end
			end
			if (s_tvalid && s_tready)
				interpolate_sample(s_tdata);
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_FROM_RATE: begin
						from_rate = cfg_data;
						src_cnt = '0;
						dst_cnt = '0;
						have_prev = 1'b0;
					end
					REG_TO_RATE: begin
						to_rate = cfg_data;
						src_cnt = '0;
						dst_cnt = '0;
						have_prev = 1'b0;
					end
					REG_CHANNEL_COUNT: chan_cfg = cfg_data[CC_W-1:0];
					REG_WIDE_SAMPLES:  wide = cfg_data[0];
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- verif/linear_interpolation_resampler_unit_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none

module linear_interpolation_resampler_unit_tb;
	import lir_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [SAMPLE_W-1:0]   s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic [0:0]            m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [RATE_W-1:0]     cfg_data;
	int                    errors;
	int                    pending;

	// stimulus control shared with the receiver process
	logic calm;        // no idling on either side
	logic hold_req;    // ask receiver for one long stall

	// settle time before a register write
	localparam int SETTLE = 1000;

	linear_interpolation_resampler_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	resample_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#40_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: random stall bursts, one long hold on request, none when calm
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_req = 1'b0;
			end else if (calm || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// register writes only once the block has gone quiet
	task automatic write_reg(cfg_reg_t idx, logic [RATE_W-1:0] val);
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(logic [31:0] v);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_7FFF;
			3: return 32'hFFFF_8000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [RATE_W-1:0] pick_rate();
		case ($urandom_range(0, 5))
			0: return 25'd100;
			1: return 25'd19200000;
			2: return 25'd4410000;
			3: return 25'd4800000;
			default: return RATE_W'($urandom_range(100, 19200000));
		endcase
	endfunction

	initial begin
		logic [31:0] edge_vals[12];
		int          n_items;
		edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h0000_7FFF, 32'h0000_8000, 32'hFFFF_8000, 32'h5555_AAAA,
			32'hAAAA_5555, 32'h0000_0001, 32'h8000_7FFF, 32'h7FFF_8000};
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_FROM_RATE;
		cfg_data  = '0;
		calm      = 1'b0;
		hold_req  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: two channels, 16-bit, equal rates
		for (int i = 0; i < 6; i++)
			send_sample(edge_vals[i]);

		// full 8-channel frames write every frame entry, wide, upsampling
		write_reg(REG_CHANNEL_COUNT, RATE_W'(8));
		write_reg(REG_WIDE_SAMPLES, RATE_W'(1));
		write_reg(REG_FROM_RATE, 25'd4410000);
		write_reg(REG_TO_RATE, 25'd4800000);
		for (int i = 0; i < 16; i++)
			send_sample(edge_vals[i % 12]);

		// clipping: huge upsample, 64 results per frame; hold the receiver meanwhile
		write_reg(REG_FROM_RATE, 25'd100);
		write_reg(REG_TO_RATE, 25'd19200000);
		hold_req = 1'b1;
		for (int i = 0; i < 24; i++)
			send_sample(pick_sample());

		// channel count shrinks mid-frame: next sample closes the frame
		write_reg(REG_CHANNEL_COUNT, RATE_W'(4));
		write_reg(REG_FROM_RATE, 25'd4800000);
		write_reg(REG_TO_RATE, 25'd9600000);
		for (int i = 0; i < 7; i++)
			send_sample(pick_sample());
		write_reg(REG_CHANNEL_COUNT, RATE_W'(2));
		send_sample(pick_sample());
		// sample mode flips mid-frame
		send_sample(32'h0001_8000);
		write_reg(REG_WIDE_SAMPLES, RATE_W'(0));
		send_sample(32'h1234_7FFF);

		// zero rates, zero and oversized channel counts
		write_reg(REG_FROM_RATE, 25'd0);
		write_reg(REG_TO_RATE, 25'd0);
		write_reg(REG_CHANNEL_COUNT, RATE_W'(0));
		for (int i = 0; i < 6; i++)
			send_sample(pick_sample());
		write_reg(REG_CHANNEL_COUNT, RATE_W'(15));
		write_reg(REG_FROM_RATE, 25'd19200000);
		write_reg(REG_TO_RATE, 25'd100);
		for (int i = 0; i < 16; i++)
			send_sample(pick_sample());

		// random phases; last one without idling
		n_items = 0;
		for (int ph = 0; n_items < 370; ph++) begin
			int cnt;
			write_reg(REG_FROM_RATE, pick_rate());
			write_reg(REG_TO_RATE, pick_rate());
			write_reg(REG_CHANNEL_COUNT, RATE_W'($urandom_range(1, 8)));
			write_reg(REG_WIDE_SAMPLES, RATE_W'($urandom_range(0, 1)));
			if (n_items >= 310)
				calm = 1'b1;
			cnt = $urandom_range(20, 60);
			for (int i = 0; i < cnt; i++) begin
				send_sample(pick_sample());
				// once, the sender waits for every result to come back
				if (ph == 2 && i == cnt / 2) begin
					s_tvalid <= 1'b0;
					wait_drained();
				end
			end
			n_items += cnt;
		end
		s_tvalid <= 1'b0;

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/lir_pkg.sv
hw/rtl/lir_front.sv
hw/rtl/lir_fifo.sv
hw/rtl/lir_div.sv
hw/rtl/lir_back.sv
hw/rtl/linear_interpolation_resampler_unit.sv
hw/rtl/lir_checker.sv
verif/resample_checker.sv
verif/linear_interpolation_resampler_unit_tb.sv
